### rtl/gjdv_pkg.sv
`timescale 1ns / 1ps

package gjdv_pkg;

	// result codes, first failing check wins
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DATATYPE = 3'd1,
		ST_ZERO_DIM = 3'd2,
		ST_EXCEEDS  = 3'd3,
		ST_STRIDE   = 3'd4,
		ST_ADDRESS  = 3'd5,
		ST_OVERLAP  = 3'd6
	} status_t;

	localparam int FMT_W = 8;
	localparam logic [FMT_W-1:0] FMT_INT8 = 8'd0;
	localparam logic [FMT_W-1:0] FMT_FP16 = 8'd1;
	localparam logic [FMT_W-1:0] FMT_BF16 = 8'd2;

	localparam int PITCH_W = 32;
	localparam int DT_MASK_W = 3;
	// result elements are four bytes wide for every datatype
	localparam int RES_SHIFT = 2;
	// footprints and region ends saturate at this many bits
	localparam int SAT_BITS = 64;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_COLUMNS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CAP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DT_MASK       = 3'd4;

	localparam int ARRAY_DIM_RST = 64;
	localparam logic [DT_MASK_W-1:0] DT_MASK_RST = 3'b111;

endpackage

### rtl/gjdv_ifs.sv
`timescale 1ns / 1ps

interface gjdv_desc_if #(
	parameter int ADDRESS_WIDTH   = 48,
	parameter int DIMENSION_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic [gjdv_pkg::FMT_W-1:0]      data_format;
	logic [DIMENSION_WIDTH-1:0]      dim_m;
	logic [DIMENSION_WIDTH-1:0]      dim_n;
	logic [DIMENSION_WIDTH-1:0]      dim_k;
	logic [ADDRESS_WIDTH-1:0]        addr_a;
	logic [ADDRESS_WIDTH-1:0]        addr_b;
	logic [ADDRESS_WIDTH-1:0]        addr_c;
	logic [gjdv_pkg::PITCH_W-1:0]    pitch_a;
	logic [gjdv_pkg::PITCH_W-1:0]    pitch_b;
	logic [gjdv_pkg::PITCH_W-1:0]    pitch_c;

	modport source (
		output valid, data_format, dim_m, dim_n, dim_k,
		output addr_a, addr_b, addr_c, pitch_a, pitch_b, pitch_c,
		input  ready
	);
	modport sink (
		input  valid, data_format, dim_m, dim_n, dim_k,
		input  addr_a, addr_b, addr_c, pitch_a, pitch_b, pitch_c,
		output ready
	);
endinterface

interface gjdv_status_if;
	logic              valid;
	logic              ready;
	gjdv_pkg::status_t status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

interface gjdv_cfg_if #(
	parameter int ADDRESS_WIDTH = 48
);
	logic                             valid;
	logic                             ready;
	logic [gjdv_pkg::CFG_IDX_W-1:0]   index;
	logic [ADDRESS_WIDTH-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/gjdv_region.sv
`timescale 1ns / 1ps

// footprint of one operand region, its saturated end address and the window fit
module gjdv_region #(
	parameter int AW  = 48,
	parameter int PW  = 50,
	parameter int RBW = 18,
	parameter int XW  = 65
) (
	input  logic [AW-1:0]  addr,
	input  logic [AW-1:0]  base,
	input  logic [AW-1:0]  cap,
	input  logic [PW-1:0]  prod,
	input  logic [RBW-1:0] row_len,
	output logic [XW-1:0]  len,
	output logic [XW-1:0]  limit,
	output logic           fits
);

	localparam logic [XW-1:0] SAT_MAX =
		{{(XW-gjdv_pkg::SAT_BITS){1'b0}}, {gjdv_pkg::SAT_BITS{1'b1}}};

	logic [XW-1:0] raw_len;
	logic [XW-1:0] raw_end;
	logic [AW-1:0] off;

	assign raw_len = XW'(prod) + XW'(row_len);
	assign len     = (raw_len > SAT_MAX) ? SAT_MAX : raw_len;
	assign raw_end = XW'(addr) + len;
	assign limit   = (raw_end > SAT_MAX) ? SAT_MAX : raw_end;

	assign off  = addr - base;
	assign fits = (addr >= base) && (off <= cap) && (len <= XW'(cap - off));

endmodule

### rtl/gemm_job_descriptor_validator.sv
`timescale 1ns / 1ps
// path: an accepted descriptor passes the input, product and status registers,
//   and the status register drives result; throughput is one descriptor per cycle
//   unless result.ready stalls; each of the three register stages (input, product,
//   status) loads whenever it is empty or the stage after it moves on
// reset: clears all stage valid bits and loads the configuration reset values
module gemm_job_descriptor_validator #(
	parameter int ADDRESS_WIDTH   = 48,
	parameter int DIMENSION_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gjdv_cfg_if.sink             cfg,
	gjdv_desc_if.sink            desc,
	gjdv_status_if.source        result
);

	localparam int AW  = ADDRESS_WIDTH;
	localparam int DW  = DIMENSION_WIDTH;
	localparam int RBW = DW + 2;
	localparam int STW = (RBW > gjdv_pkg::PITCH_W) ? RBW : gjdv_pkg::PITCH_W;
	localparam int PW  = DW + STW;
	localparam int FW  = PW + 1;
	localparam int XW  = ((FW > gjdv_pkg::SAT_BITS) ? FW : gjdv_pkg::SAT_BITS) + 1;

	// configuration
	logic [DW-1:0]                  rows_q;
	logic [DW-1:0]                  cols_q;
	logic [AW-1:0]                  base_q;
	logic [AW-1:0]                  cap_q;
	logic [gjdv_pkg::DT_MASK_W-1:0] dt_mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= DW'(gjdv_pkg::ARRAY_DIM_RST);
			cols_q    <= DW'(gjdv_pkg::ARRAY_DIM_RST);
			base_q    <= '0;
			cap_q     <= '0;
			dt_mask_q <= gjdv_pkg::DT_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gjdv_pkg::CFG_ARRAY_ROWS:    rows_q    <= cfg.data[DW-1:0];
				gjdv_pkg::CFG_ARRAY_COLUMNS: cols_q    <= cfg.data[DW-1:0];
				gjdv_pkg::CFG_WINDOW_BASE:   base_q    <= cfg.data;
				gjdv_pkg::CFG_WINDOW_CAP:    cap_q     <= cfg.data;
				gjdv_pkg::CFG_DT_MASK:       dt_mask_q <= cfg.data[gjdv_pkg::DT_MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	logic v_s1, v_s2, out_v_q;
	logic ld_out, en2, en1;

	assign ld_out     = !out_v_q || result.ready;
	assign en2        = !v_s2 || ld_out;
	assign en1        = !v_s1 || en2;
	assign desc.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= desc.valid;
			if (en2)
				v_s2 <= v_s1;
			if (ld_out)
				out_v_q <= v_s2;
		end
	end

	// stage 1: registered descriptor
	logic [gjdv_pkg::FMT_W-1:0]   fmt_s1;
	logic [DW-1:0]                m_s1, n_s1, k_s1;
	logic [AW-1:0]                aa_s1, ab_s1, ac_s1;
	logic [gjdv_pkg::PITCH_W-1:0] pa_s1, pb_s1, pc_s1;

	always_ff @(posedge clk) begin
		if (en1 && desc.valid) begin
			fmt_s1 <= desc.data_format;
			m_s1   <= desc.dim_m;
			n_s1   <= desc.dim_n;
			k_s1   <= desc.dim_k;
			aa_s1  <= desc.addr_a;
			ab_s1  <= desc.addr_b;
			ac_s1  <= desc.addr_c;
			pa_s1  <= desc.pitch_a;
			pb_s1  <= desc.pitch_b;
			pc_s1  <= desc.pitch_c;
		end
	end

	// field checks, row bytes and strides
	logic                fmt_known, op2, dt_on;
	logic [RBW-1:0]      ra, rb, rc;
	logic [STW-1:0]      sa, sb, sc;
	logic                stride_bad;
	gjdv_pkg::status_t   early;

	always_comb begin
		fmt_known = 1'b1;
		op2       = 1'b0;
		dt_on     = 1'b0;
		unique case (fmt_s1)
			gjdv_pkg::FMT_INT8: dt_on = dt_mask_q[0];
			gjdv_pkg::FMT_FP16: begin
				op2   = 1'b1;
				dt_on = dt_mask_q[1];
			end
			gjdv_pkg::FMT_BF16: begin
				op2   = 1'b1;
				dt_on = dt_mask_q[2];
			end
			default: fmt_known = 1'b0;
		endcase
	end

	assign ra = RBW'(k_s1) << op2;
	assign rb = RBW'(n_s1) << op2;
	assign rc = RBW'(n_s1) << gjdv_pkg::RES_SHIFT;

	// a zero pitch means packed rows
	assign sa = (pa_s1 != '0) ? STW'(pa_s1) : STW'(ra);
	assign sb = (pb_s1 != '0) ? STW'(pb_s1) : STW'(rb);
	assign sc = (pc_s1 != '0) ? STW'(pc_s1) : STW'(rc);

	assign stride_bad = (sa < STW'(ra)) || (sb < STW'(rb)) || (sc < STW'(rc));

	always_comb begin
		priority if (!fmt_known || !dt_on)
			early = gjdv_pkg::ST_DATATYPE;
		else if (m_s1 == '0 || n_s1 == '0 || k_s1 == '0)
			early = gjdv_pkg::ST_ZERO_DIM;
		else if (n_s1 > cols_q || m_s1 > rows_q)
			early = gjdv_pkg::ST_EXCEEDS;
		else if (stride_bad)
			early = gjdv_pkg::ST_STRIDE;
		else
			early = gjdv_pkg::ST_OK;
	end

	// stage 2: (rows-1)*stride products
	gjdv_pkg::status_t early_s2;
	logic [PW-1:0]     prod_a_s2, prod_b_s2, prod_c_s2;
	logic [RBW-1:0]    ra_s2, rb_s2, rc_s2;
	logic [AW-1:0]     aa_s2, ab_s2, ac_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			early_s2  <= early;
			prod_a_s2 <= PW'(m_s1 - DW'(1)) * PW'(sa);
			prod_b_s2 <= PW'(k_s1 - DW'(1)) * PW'(sb);
			prod_c_s2 <= PW'(m_s1 - DW'(1)) * PW'(sc);
			ra_s2     <= ra;
			rb_s2     <= rb;
			rc_s2     <= rc;
			aa_s2     <= aa_s1;
			ab_s2     <= ab_s1;
			ac_s2     <= ac_s1;
		end
	end

	logic [XW-1:0] len_a, len_b, len_c;
	logic [XW-1:0] lim_a, lim_b, lim_c;
	logic          fit_a, fit_b, fit_c;

	gjdv_region #(.AW(AW), .PW(PW), .RBW(RBW), .XW(XW)) u_region_a (
		.addr(aa_s2), .base(base_q), .cap(cap_q), .prod(prod_a_s2),
		.row_len(ra_s2), .len(len_a), .limit(lim_a), .fits(fit_a)
	);
	gjdv_region #(.AW(AW), .PW(PW), .RBW(RBW), .XW(XW)) u_region_b (
		.addr(ab_s2), .base(base_q), .cap(cap_q), .prod(prod_b_s2),
		.row_len(rb_s2), .len(len_b), .limit(lim_b), .fits(fit_b)
	);
	gjdv_region #(.AW(AW), .PW(PW), .RBW(RBW), .XW(XW)) u_region_c (
		.addr(ac_s2), .base(base_q), .cap(cap_q), .prod(prod_c_s2),
		.row_len(rc_s2), .len(len_c), .limit(lim_c), .fits(fit_c)
	);

	// empty regions never overlap
	logic ov_ca, ov_cb;
	assign ov_ca = (len_c != '0) && (len_a != '0) &&
		(XW'(ac_s2) < lim_a) && (XW'(aa_s2) < lim_c);
	assign ov_cb = (len_c != '0) && (len_b != '0) &&
		(XW'(ac_s2) < lim_b) && (XW'(ab_s2) < lim_c);

	gjdv_pkg::status_t final_st;

	always_comb begin
		priority if (early_s2 != gjdv_pkg::ST_OK)
			final_st = early_s2;
		else if (!fit_a || !fit_b || !fit_c)
			final_st = gjdv_pkg::ST_ADDRESS;
		else if (ov_ca || ov_cb)
			final_st = gjdv_pkg::ST_OVERLAP;
		else
			final_st = gjdv_pkg::ST_OK;
	end

	gjdv_pkg::status_t status_q;

	always_ff @(posedge clk) begin
		if (ld_out && v_s2)
			status_q <= final_st;
	end

	assign result.valid  = out_v_q;
	assign result.status = status_q;

	// an accepted beat always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		desc.valid && desc.ready |=> v_s1)
		else $error("accepted descriptor missing from stage 1");

	// an early failure code passes straight to the output
	a_early_kept: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && v_s2 && early_s2 != gjdv_pkg::ST_OK
		|=> result.status == $past(early_s2))
		else $error("early status overridden");

	// zero dimension on an enabled format is reported as such
	a_zero_dim: assert property (@(posedge clk) disable iff (!arst_n)
		en2 && v_s1 && fmt_known && dt_on && (m_s1 == '0 || n_s1 == '0 || k_s1 == '0)
		|=> early_s2 == gjdv_pkg::ST_ZERO_DIM)
		else $error("zero dimension not flagged");

	// the input stalls only when every stage is full and result.ready is low
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!desc.ready |-> (v_s1 && v_s2 && out_v_q && !result.ready))
		else $error("input stalled with room in the pipeline");

endmodule
